// ===== rtl/qisd_pkg.sv =====
// shared types and constants for the quadtree image stream decoder
`default_nettype none
package qisd_pkg;

  // largest log2 image side accepted in a header
  localparam int MAX_LOG_SIDE = 10;

  // widths of the stream and fill fields
  localparam int BYTE_W      = 8;
  localparam int FILL_POS_W  = 10;
  localparam int FILL_SIDE_W = 11;
  localparam int ERR_W       = 2;

  // internal widths that follow from the side limit
  localparam int SIDE_W  = MAX_LOG_SIDE + 1;
  localparam int DEPTH_W = $clog2(MAX_LOG_SIDE + 1);

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // node and filler byte codes
  localparam logic [BYTE_W-1:0] NODE_INNER = 8'd0;
  localparam logic [BYTE_W-1:0] NODE_LEAF  = 8'd1;
  localparam logic [BYTE_W-1:0] FILLER     = 8'd2;

  // error codes carried on a fill request
  localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_NODE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_TOO_DEEP = 2'd2;
  localparam logic [ERR_W-1:0] ERR_HDR_BIG  = 2'd3;

  // one classified stream byte
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              start;
    logic              hdr_big;
    logic              is_inner;
    logic              is_leaf;
    logic              is_filler;
  } token_t;

endpackage
`default_nettype wire

// ===== rtl/qisd_front.sv =====
// front stage: takes stream bytes and classifies them into tokens
`default_nettype none
module qisd_front (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire  [qisd_pkg::BYTE_W-1:0] stream_byte_i,
  input  wire                         stream_start_i,
  output logic                        tok_valid_o,
  input  wire                         tok_ready_i,
  output qisd_pkg::token_t            tok_o
);
  import qisd_pkg::*;

  logic   tok_valid_q, tok_valid_d;
  token_t tok_q, tok_d;

  // stage is free when empty or draining into the queue
  assign in_ready_o = !tok_valid_q || tok_ready_i;

  // classify the incoming byte
  always_comb begin
    tok_d           = tok_q;
    tok_valid_d     = tok_valid_q;
    if (tok_ready_i) begin
      tok_valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      tok_valid_d       = 1'b1;
      tok_d.data        = stream_byte_i;
      tok_d.start       = stream_start_i;
      tok_d.hdr_big     = stream_byte_i > BYTE_W'(MAX_LOG_SIDE);
      tok_d.is_inner    = stream_byte_i == NODE_INNER;
      tok_d.is_leaf     = stream_byte_i == NODE_LEAF;
      tok_d.is_filler   = stream_byte_i == FILLER;
    end
  end

  // control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule
`default_nettype wire

// ===== rtl/qisd_queue.sv =====
// short token queue between the front and back stages
`default_nettype none
module qisd_queue (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_valid_i,
  output logic              push_ready_o,
  input  qisd_pkg::token_t  push_data_i,
  output logic              pop_valid_o,
  input  wire               pop_ready_i,
  output qisd_pkg::token_t  pop_data_o
);
  import qisd_pkg::*;

  token_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign push_ready_o = count_q != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qisd_back.sv =====
// back stage: walks the tree, keeps the path stack and drives fill requests
`default_nettype none
module qisd_back (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              tok_valid_i,
  output logic                             tok_ready_o,
  input  qisd_pkg::token_t                 tok_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [qisd_pkg::FILL_POS_W-1:0]  fill_x_o,
  output logic [qisd_pkg::FILL_POS_W-1:0]  fill_y_o,
  output logic [qisd_pkg::FILL_SIDE_W-1:0] fill_side_o,
  output logic [qisd_pkg::BYTE_W-1:0]      red_o,
  output logic [qisd_pkg::BYTE_W-1:0]      green_o,
  output logic [qisd_pkg::BYTE_W-1:0]      blue_o,
  output logic                             last_fill_o,
  output logic [qisd_pkg::ERR_W-1:0]       error_code_o
);
  import qisd_pkg::*;

  // decoder phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_FILLER = 3'd1;
  localparam logic [2:0] PH_NODE   = 3'd2;
  localparam logic [2:0] PH_COLOUR = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;
  localparam logic [2:0] PH_ERROR  = 3'd5;

  logic [2:0]         phase_q, phase_d;
  logic [DEPTH_W-1:0] log_side_q, log_side_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [1:0]         stack_q [MAX_LOG_SIDE];
  logic [1:0]         stack_d [MAX_LOG_SIDE];
  logic [1:0]         ccount_q, ccount_d;
  logic [BYTE_W-1:0]  held_red_q, held_red_d;
  logic [BYTE_W-1:0]  held_green_q, held_green_d;

  logic                   out_valid_q, out_valid_d;
  logic [FILL_POS_W-1:0]  fill_x_q, fill_x_d;
  logic [FILL_POS_W-1:0]  fill_y_q, fill_y_d;
  logic [FILL_SIDE_W-1:0] fill_side_q, fill_side_d;
  logic [BYTE_W-1:0]      red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic                   last_q, last_d;
  logic [ERR_W-1:0]       err_q, err_d;

  logic                   fire, take_node, emit_err, emit_leaf;
  logic [ERR_W-1:0]       err_code;
  logic [SIDE_W-1:0]      x_v, y_v, side_v;
  logic [DEPTH_W-1:0]     next_depth;

  // a token is taken when the output register is free or drains
  assign tok_ready_o = !out_valid_q || out_ready_i;
  assign fire        = tok_valid_i && tok_ready_o;

  // square position from the path stack, one bit per level
  always_comb begin
    int pos;
    x_v = '0;
    y_v = '0;
    for (int i = 0; i < MAX_LOG_SIDE; i++) begin
      pos = int'(log_side_q) - 1 - i;
      if (i < int'(depth_q) && pos >= 0) begin
        x_v = x_v | (SIDE_W'(stack_q[i][0]) << pos);
        y_v = y_v | (SIDE_W'(stack_q[i][1]) << pos);
      end
    end
    side_v = (SIDE_W'(1) << log_side_q) >> depth_q;
  end

  // deepest unfinished parent on the path
  always_comb begin
    next_depth = '0;
    for (int i = 0; i < MAX_LOG_SIDE; i++) begin
      if (i < int'(depth_q) && stack_q[i] != 2'd3) begin
        next_depth = DEPTH_W'(i + 1);
      end
    end
  end

  // decoder state update
  always_comb begin
    phase_d      = phase_q;
    log_side_d   = log_side_q;
    depth_d      = depth_q;
    stack_d      = stack_q;
    ccount_d     = ccount_q;
    held_red_d   = held_red_q;
    held_green_d = held_green_q;
    take_node    = 1'b0;
    emit_err     = 1'b0;
    emit_leaf    = 1'b0;
    err_code     = ERR_OK;
    last_d       = 1'b0;

    if (fire) begin
      if (tok_i.start) begin
        depth_d  = '0;
        ccount_d = '0;
        for (int i = 0; i < MAX_LOG_SIDE; i++) begin
          stack_d[i] = '0;
        end
        if (tok_i.hdr_big) begin
          log_side_d = '0;
          emit_err   = 1'b1;
          err_code   = ERR_HDR_BIG;
        end else begin
          log_side_d = tok_i.data[DEPTH_W-1:0];
          phase_d    = PH_FILLER;
        end
      end else begin
        unique case (phase_q)
          PH_FILLER: take_node = !tok_i.is_filler;
          PH_NODE:   take_node = 1'b1;
          PH_COLOUR: begin
            if (ccount_q == 2'd0) begin
              held_red_d = tok_i.data;
              ccount_d   = 2'd1;
            end else if (ccount_q == 2'd1) begin
              held_green_d = tok_i.data;
              ccount_d     = 2'd2;
            end else begin
              emit_leaf = 1'b1;
              ccount_d  = '0;
              depth_d   = next_depth;
              if (next_depth == '0) begin
                last_d  = 1'b1;
                phase_d = PH_DONE;
              end else begin
                phase_d = PH_NODE;
                for (int i = 0; i < MAX_LOG_SIDE; i++) begin
                  if (DEPTH_W'(i + 1) == next_depth) begin
                    stack_d[i] = stack_q[i] + 2'd1;
                  end
                end
              end
            end
          end
          default: ;
        endcase
      end

      // node byte handling
      if (take_node) begin
        if (tok_i.is_inner) begin
          if (depth_q >= log_side_q) begin
            emit_err = 1'b1;
            err_code = ERR_TOO_DEEP;
          end else begin
            for (int i = 0; i < MAX_LOG_SIDE; i++) begin
              if (DEPTH_W'(i) == depth_q) begin
                stack_d[i] = '0;
              end
            end
            depth_d = depth_q + 1'b1;
            phase_d = PH_NODE;
          end
        end else if (tok_i.is_leaf) begin
          ccount_d = '0;
          phase_d  = PH_COLOUR;
        end else begin
          emit_err = 1'b1;
          err_code = ERR_BAD_NODE;
        end
      end

      if (emit_err) begin
        phase_d = PH_ERROR;
      end
    end
  end

  // output register load
  always_comb begin
    out_valid_d = out_valid_q;
    fill_x_d    = fill_x_q;
    fill_y_d    = fill_y_q;
    fill_side_d = fill_side_q;
    red_d       = red_q;
    green_d     = green_q;
    blue_d      = blue_q;
    err_d       = err_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit_err) begin
      out_valid_d = 1'b1;
      fill_x_d    = '0;
      fill_y_d    = '0;
      fill_side_d = '0;
      red_d       = '0;
      green_d     = '0;
      blue_d      = '0;
      err_d       = err_code;
    end else if (emit_leaf) begin
      out_valid_d = 1'b1;
      fill_x_d    = x_v[FILL_POS_W-1:0];
      fill_y_d    = y_v[FILL_POS_W-1:0];
      fill_side_d = FILL_SIDE_W'(side_v);
      red_d       = held_red_q;
      green_d     = held_green_q;
      blue_d      = tok_i.data;
      err_d       = ERR_OK;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      log_side_q   <= '0;
      depth_q      <= '0;
      ccount_q     <= '0;
      held_red_q   <= '0;
      held_green_q <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < MAX_LOG_SIDE; i++) begin
        stack_q[i] <= '0;
      end
    end else begin
      phase_q      <= phase_d;
      log_side_q   <= log_side_d;
      depth_q      <= depth_d;
      ccount_q     <= ccount_d;
      held_red_q   <= held_red_d;
      held_green_q <= held_green_d;
      out_valid_q  <= out_valid_d;
      stack_q      <= stack_d;
    end
  end

  // fill request payload
  always_ff @(posedge clk_i) begin
    fill_x_q    <= fill_x_d;
    fill_y_q    <= fill_y_d;
    fill_side_q <= fill_side_d;
    red_q       <= red_d;
    green_q     <= green_d;
    blue_q      <= blue_d;
    err_q       <= err_d;
    if (emit_err || emit_leaf) begin
      last_q <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign fill_x_o     = fill_x_q;
  assign fill_y_o     = fill_y_q;
  assign fill_side_o  = fill_side_q;
  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;
  assign last_fill_o  = last_q;
  assign error_code_o = err_q;

endmodule
`default_nettype wire

// ===== rtl/quadtree_image_stream_decoder.sv =====
// top level of the quadtree image stream decoder
//
// Input channel (in_valid_i / in_ready_o) takes one stream byte per request;
// stream_start_i marks the header byte holding log2 of the image side.
// Output channel (out_valid_o / out_ready_i) gives one fill request per leaf:
// square corner, side and colour, last_fill_o on the leaf that ends the
// tree, or a single request with error_code_o set when the stream is bad.
// Throughput: one byte per cycle while the output is not stalled, set by the
// back stage, which updates the path stack and counters once per byte.
// A fill request passes from its accepted blue byte through the front register
// and the queue entry, then through the back stage into the output register.
// A four-entry queue sits between the front and back stages.
// Reset clears all stages and the queue; the decoder waits for a header.
// When the receiver stalls the output register holds its request, the back
// stage stops, the queue fills and then in_ready_o drops.
`default_nettype none
module quadtree_image_stream_decoder (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [qisd_pkg::BYTE_W-1:0]      stream_byte_i,
  input  wire                              stream_start_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [qisd_pkg::FILL_POS_W-1:0]  fill_x_o,
  output logic [qisd_pkg::FILL_POS_W-1:0]  fill_y_o,
  output logic [qisd_pkg::FILL_SIDE_W-1:0] fill_side_o,
  output logic [qisd_pkg::BYTE_W-1:0]      red_o,
  output logic [qisd_pkg::BYTE_W-1:0]      green_o,
  output logic [qisd_pkg::BYTE_W-1:0]      blue_o,
  output logic                             last_fill_o,
  output logic [qisd_pkg::ERR_W-1:0]       error_code_o
);
  import qisd_pkg::*;

  logic   ftok_valid, ftok_ready;
  token_t ftok;
  logic   btok_valid, btok_ready;
  token_t btok;

  // byte classification
  qisd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .stream_byte_i  (stream_byte_i),
    .stream_start_i (stream_start_i),
    .tok_valid_o    (ftok_valid),
    .tok_ready_i    (ftok_ready),
    .tok_o          (ftok)
  );

  // decoupling queue
  qisd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (ftok_valid),
    .push_ready_o (ftok_ready),
    .push_data_i  (ftok),
    .pop_valid_o  (btok_valid),
    .pop_ready_i  (btok_ready),
    .pop_data_o   (btok)
  );

  // tree walk and fill requests
  qisd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tok_valid_i  (btok_valid),
    .tok_ready_o  (btok_ready),
    .tok_i        (btok),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .fill_x_o     (fill_x_o),
    .fill_y_o     (fill_y_o),
    .fill_side_o  (fill_side_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .last_fill_o  (last_fill_o),
    .error_code_o (error_code_o)
  );

endmodule
`default_nettype wire

// ===== rtl/qisd_checker.sv =====
// port-level checks for the quadtree image stream decoder, with bind
`default_nettype none
module qisd_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              out_valid_o,
  input wire                              out_ready_i,
  input wire [qisd_pkg::FILL_POS_W-1:0]   fill_x_o,
  input wire [qisd_pkg::FILL_POS_W-1:0]   fill_y_o,
  input wire [qisd_pkg::FILL_SIDE_W-1:0]  fill_side_o,
  input wire                              last_fill_o,
  input wire [qisd_pkg::ERR_W-1:0]        error_code_o
);
  import qisd_pkg::*;

  // a stalled request holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(fill_x_o)
      && $stable(fill_y_o) && $stable(fill_side_o) && $stable(error_code_o))
    else $error("stalled fill request changed");

  // error requests never end a tree
  a_err_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != ERR_OK |-> !last_fill_o)
    else $error("error request flagged as last fill");

  // error requests carry an empty square
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != ERR_OK |->
      fill_x_o == '0 && fill_y_o == '0 && fill_side_o == '0)
    else $error("error request with nonzero square");

  // a leaf always covers at least one pixel
  a_leaf_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o == ERR_OK |-> fill_side_o != '0)
    else $error("leaf fill with zero side");

endmodule

bind quadtree_image_stream_decoder qisd_checker u_qisd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .fill_x_o     (fill_x_o),
  .fill_y_o     (fill_y_o),
  .fill_side_o  (fill_side_o),
  .last_fill_o  (last_fill_o),
  .error_code_o (error_code_o)
);
`default_nettype wire
